@@ sv/signed_int_to_decimal_ascii_defines.svh @@
// Assertion macros used by the checker module.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define SIDEC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check that also runs through reset.
`define SIDEC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ sv/sidec_pkg.sv @@
`default_nettype none

package sidec_pkg;

  // Magnitude bits folded into the BCD register per conversion step.
  localparam int BITS_PER_STEP = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CONV,
    OP_SIGN,
    OP_DIGIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NO_BEAT,
    COND_CONV_MORE,
    COND_SIGN_WAIT,
    COND_DIGIT_MORE
  } cond_t;

  localparam int PC_W = 2;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_LOAD  = 2'd0;
  localparam pc_t PC_CONV  = 2'd1;
  localparam pc_t PC_SIGN  = 2'd2;
  localparam pc_t PC_DIGIT = 2'd3;

  // One control word: datapath op, jump condition, jump target, and
  // whether a failed condition returns to the load step instead of falling through.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  ret;
  } ctrl_t;

  typedef struct packed {
    logic no_beat;
    logic conv_more;
    logic sign_wait;
    logic digit_more;
  } stat_t;

  // Microprogram ROM.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_BEAT,    target: PC_LOAD,  ret: 1'b0};
      PC_CONV:  w = '{op: OP_CONV,  cond: COND_CONV_MORE,  target: PC_CONV,  ret: 1'b0};
      PC_SIGN:  w = '{op: OP_SIGN,  cond: COND_SIGN_WAIT,  target: PC_SIGN,  ret: 1'b0};
      PC_DIGIT: w = '{op: OP_DIGIT, cond: COND_DIGIT_MORE, target: PC_DIGIT, ret: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/sidec_seq.sv @@
`default_nettype none

module sidec_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sidec_pkg::stat_t    stat,
  output sidec_pkg::ctrl_t    ctrl
);

  sidec_pkg::pc_t pc_r;
  sidec_pkg::pc_t pc_nxt;
  logic           jump;

  assign ctrl = sidec_pkg::ucode(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      sidec_pkg::COND_NO_BEAT:    jump = stat.no_beat;
      sidec_pkg::COND_CONV_MORE:  jump = stat.conv_more;
      sidec_pkg::COND_SIGN_WAIT:  jump = stat.sign_wait;
      sidec_pkg::COND_DIGIT_MORE: jump = stat.digit_more;
    endcase
    if (jump) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.ret) begin
      pc_nxt = sidec_pkg::PC_LOAD;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sidec_pkg::PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/sidec_dp.sv @@
`default_nettype none

module sidec_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  sidec_pkg::ctrl_t             ctrl,
  output sidec_pkg::stat_t             stat,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [VALUE_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  localparam int BPS    = sidec_pkg::BITS_PER_STEP;
  localparam int STEPS  = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int CW     = STEPS * BPS;
  localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int IDX_W  = $clog2(NDIG);

  logic                   neg_r, neg_nxt;
  logic [CW-1:0]          mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_beat;
  logic                   out_take;
  logic                   emit;
  logic [VALUE_WIDTH-1:0] v_u;
  logic [VALUE_WIDTH-1:0] abs_v;
  logic [BCD_W-1:0]       bcd_c;
  logic [CW-1:0]          mag_c;
  logic [IDX_W-1:0]       lead;
  logic [3:0]             digit;

  assign in_stall = (ctrl.op != sidec_pkg::OP_LOAD);
  assign in_beat  = in_valid && !in_stall;
  assign out_take = !out_valid_r || !out_stall;

  assign v_u   = $unsigned(in_value);
  assign abs_v = v_u[VALUE_WIDTH-1] ? (~v_u + 1'b1) : v_u;

  // Shift-and-add-3, BPS bits per cycle.
  always_comb begin
    bcd_c = bcd_r;
    mag_c = mag_r;
    for (int b = 0; b < BPS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_c[d*4 +: 4] >= 4'd5) begin
          bcd_c[d*4 +: 4] = bcd_c[d*4 +: 4] + 4'd3;
        end
      end
      bcd_c = {bcd_c[BCD_W-2:0], mag_c[CW-1]};
      mag_c = {mag_c[CW-2:0], 1'b0};
    end
  end

  // Top nonzero digit; zero lands on digit 0.
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign digit = bcd_r[idx_r*4 +: 4];

  always_comb begin
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    bcd_nxt           = bcd_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    emit              = 1'b0;
    unique case (ctrl.op)
      sidec_pkg::OP_LOAD: begin
        if (in_beat) begin
          neg_nxt = v_u[VALUE_WIDTH-1];
          mag_nxt = CW'(abs_v);
          bcd_nxt = '0;
          cnt_nxt = CNT_W'(STEPS - 1);
        end
      end
      sidec_pkg::OP_CONV: begin
        bcd_nxt = bcd_c;
        mag_nxt = mag_c;
        cnt_nxt = cnt_r - 1'b1;
      end
      sidec_pkg::OP_SIGN: begin
        idx_nxt = lead;
        if (neg_r && out_take) begin
          emit              = 1'b1;
          out_character_nxt = sidec_pkg::ASCII_MINUS;
          out_last_nxt      = 1'b0;
        end
      end
      sidec_pkg::OP_DIGIT: begin
        if (out_take) begin
          emit              = 1'b1;
          out_character_nxt = sidec_pkg::ASCII_ZERO + {4'd0, digit};
          out_last_nxt      = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  assign stat.no_beat    = !in_valid;
  assign stat.conv_more  = (cnt_r != '0);
  assign stat.sign_wait  = neg_r && !out_take;
  assign stat.digit_more = !(out_take && (idx_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r           <= neg_nxt;
    mag_r           <= mag_nxt;
    bcd_r           <= bcd_nxt;
    cnt_r           <= cnt_nxt;
    idx_r           <= idx_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// Channel | Direction | Handshake          | Payload
// in_     | sink      | in_valid/in_stall  | in_value (VALUE_WIDTH, signed)
// out_    | source    | out_valid/out_stall| out_character (8), out_last (1)
//
// Conversion runs a 4-bit-per-cycle BCD loop into a one-beat output register.
// The sign goes out during the step that locates the leading digit;
// then one digit a cycle while the output is not stalled.
// Reset (rst_n low, synchronous) returns the microprogram to the load step and
// empties the output register. Output stalls freeze the program on the current
// character; the next value is taken while the final character still waits.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [VALUE_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  // Microprogram control word and datapath flags it branches on.
  sidec_pkg::ctrl_t ctrl;
  sidec_pkg::stat_t stat;

  // Sequencer: step counter plus control-word ROM. Program:
  //   load  - wait for an input beat, take magnitude and sign
  //   conv  - double-dabble, 4 bits per pass, loops until the counter runs out
  //   sign  - find the leading digit, send '-' for a negative value
  //   digit - one digit per output beat, back to load after the last one
  sidec_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath: magnitude/BCD shift register, digit pointer, output register.
  sidec_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

@@ sv/sidec_chk.sv @@
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sidec_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_character,
  input wire       out_last
);

  logic [8:0] out_beat;
  logic       is_minus;
  logic       is_digit;

  assign out_beat = {out_character, out_last};
  assign is_minus = (out_character == sidec_pkg::ASCII_MINUS);
  assign is_digit = (out_character >= sidec_pkg::ASCII_ZERO) &&
                    (out_character <= sidec_pkg::ASCII_ZERO + 8'd9);

  `SIDEC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_beat), "stalled output beat changed")
  `SIDEC_ASSERT(a_char_legal, clk, rst_n, out_valid |-> is_minus || is_digit, "illegal character")
  `SIDEC_ASSERT(a_minus_not_last, clk, rst_n, out_valid && is_minus |-> !out_last, "minus sign flagged last")
  `SIDEC_ASSERT(a_busy_after_take, clk, rst_n, in_valid && !in_stall |=> in_stall, "input taken while converting")
  `SIDEC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind signed_int_to_decimal_ascii sidec_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);

`default_nettype wire
